@@ rtl/blam_pkg.sv @@
// Shared types and constants for the battery level averager.
package blam_pkg;

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int MV_W     = 13;
    localparam int PCT_W    = 7;
    localparam int MVP_W    = SAMPLE_W + MV_W;

    // Register port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // Register indexes, taken from address bit 2
    localparam logic REG_EMPTY_MV      = 1'b0;
    localparam logic REG_FULL_SCALE_MV = 1'b1;

    localparam logic [MV_W-1:0] EMPTY_MV_RESET      = 13'd3200;
    localparam logic [MV_W-1:0] FULL_SCALE_MV_RESET = 13'd6600;

    // Divide by 65535: q = (x + (x >> 16) + 1) >> 16
    localparam int ADC_DIV_SHIFT = 16;

    // Percentage: (mv - empty) / 10, saturating at 100
    localparam logic [PCT_W-1:0] PCT_MAX     = 7'd100;
    localparam logic [MV_W-1:0]  PCT_SAT_MV  = 13'd1000;
    localparam int               PCT_DIFF_W  = 10;
    localparam logic [7:0]       DIV10_MUL   = 8'd205;
    localparam int               DIV10_SHIFT = 11;
    localparam int               DIV10_PROD_W = PCT_DIFF_W + 8;

    // Load controls shared by every cell of the sample chain
    typedef struct packed {
        logic shift;
        logic fill;
    } t_cell_ctrl;

    // Configuration handed to the scaling pipeline
    typedef struct packed {
        logic [MV_W-1:0] empty_mv;
        logic [MV_W-1:0] full_scale_mv;
    } t_cfg;

endpackage

@@ rtl/battery_level_averager.sv @@
// Top level: register port, sample window chain and scaling pipeline.
// Each accepted sample's sum is registered, then passes the scaling stages.
// Throughput: one sample per cycle unless stalled; the chain of cells shifts
// once per sample and the running sum is updated in the same cycle.
// Reset clears the pipeline valid flags, the prefill flag and the registers to
// 3200 mV empty and 6600 mV full scale; the first sample fills every cell.
module battery_level_averager #(
    parameter int WINDOW_DEPTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [blam_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [blam_pkg::APB_DATA_W-1:0] pwdata,
    output logic [blam_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [blam_pkg::SAMPLE_W-1:0]   i_adc_sample,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [blam_pkg::SAMPLE_W-1:0]   o_window_mean,
    output logic [blam_pkg::MV_W-1:0]       o_battery_millivolts,
    output logic [blam_pkg::PCT_W-1:0]      o_charge_percent
);

    localparam int SUM_W = blam_pkg::SAMPLE_W + $clog2(WINDOW_DEPTH);

    logic [blam_pkg::MV_W-1:0] r_empty_mv;
    logic [blam_pkg::MV_W-1:0] r_full_scale_mv;
    logic                      w_reg_write;
    blam_pkg::t_cfg            w_cfg;
    logic                      w_sum_valid;
    logic                      w_sum_stall;
    logic [SUM_W-1:0]          w_sum;

    // Register port: write on the access phase, zero wait states
    assign pready      = 1'b1;
    assign w_reg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_empty_mv      <= blam_pkg::EMPTY_MV_RESET;
            r_full_scale_mv <= blam_pkg::FULL_SCALE_MV_RESET;
        end else if (w_reg_write) begin
            case (paddr[2])
                blam_pkg::REG_EMPTY_MV:      r_empty_mv      <= pwdata[blam_pkg::MV_W-1:0];
                blam_pkg::REG_FULL_SCALE_MV: r_full_scale_mv <= pwdata[blam_pkg::MV_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        case (paddr[2])
            blam_pkg::REG_EMPTY_MV:      prdata = blam_pkg::APB_DATA_W'(r_empty_mv);
            blam_pkg::REG_FULL_SCALE_MV: prdata = blam_pkg::APB_DATA_W'(r_full_scale_mv);
            default:                     prdata = '0;
        endcase
    end

    assign w_cfg.empty_mv      = r_empty_mv;
    assign w_cfg.full_scale_mv = r_full_scale_mv;

    blam_window #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .SUM_W        (SUM_W)
    ) u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .o_stall  (o_in_stall),
        .i_sample (i_adc_sample),
        .o_valid  (w_sum_valid),
        .i_stall  (w_sum_stall),
        .o_sum    (w_sum)
    );

    blam_scale #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .SUM_W        (SUM_W)
    ) u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (w_sum_valid),
        .o_stall (w_sum_stall),
        .i_sum   (w_sum),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_mean  (o_window_mean),
        .o_mv    (o_battery_millivolts),
        .o_pct   (o_charge_percent)
    );

endmodule

@@ rtl/blam_cell.sv @@
// One sample cell of the window chain: loads its neighbor or the prefill value.
module blam_cell (
    input  logic                          i_clk,
    input  blam_pkg::t_cell_ctrl          i_ctrl,
    input  logic [blam_pkg::SAMPLE_W-1:0] i_fill_data,
    input  logic [blam_pkg::SAMPLE_W-1:0] i_prev_data,
    output logic [blam_pkg::SAMPLE_W-1:0] o_data
);

    logic [blam_pkg::SAMPLE_W-1:0] r_data;

    // Prefill on the first sample, else advance from the neighbor
    always_ff @(posedge i_clk) begin
        if (i_ctrl.fill) begin
            r_data <= i_fill_data;
        end else if (i_ctrl.shift) begin
            r_data <= i_prev_data;
        end
    end

    assign o_data = r_data;

endmodule

@@ rtl/blam_window.sv @@
// Sample window: chain of cells, prefill control and running sum.
module blam_window #(
    parameter int WINDOW_DEPTH = 32,
    parameter int SUM_W        = blam_pkg::SAMPLE_W + $clog2(WINDOW_DEPTH)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [blam_pkg::SAMPLE_W-1:0] i_sample,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [SUM_W-1:0]              o_sum
);

    localparam logic [SUM_W-1:0] DEPTH_K = SUM_W'(WINDOW_DEPTH);

    logic                          r_primed;
    logic                          r_valid;
    logic [SUM_W-1:0]              r_sum;
    logic [SUM_W-1:0]              n_sum;
    logic                          w_accept;
    blam_pkg::t_cell_ctrl          w_ctrl;
    logic [blam_pkg::SAMPLE_W-1:0] w_tap [WINDOW_DEPTH];

    // Hold the sum while downstream has not taken it
    assign o_stall  = r_valid && i_stall;
    assign w_accept = i_valid && !o_stall;

    assign w_ctrl.fill  = w_accept && !r_primed;
    assign w_ctrl.shift = w_accept && r_primed;

    // Row of cells, newest at the head, oldest at the tail
    for (genvar g = 0; g < WINDOW_DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_head
            blam_cell u_cell (
                .i_clk       (i_clk),
                .i_ctrl      (w_ctrl),
                .i_fill_data (i_sample),
                .i_prev_data (i_sample),
                .o_data      (w_tap[g])
            );
        end else begin : g_body
            blam_cell u_cell (
                .i_clk       (i_clk),
                .i_ctrl      (w_ctrl),
                .i_fill_data (i_sample),
                .i_prev_data (w_tap[g-1]),
                .o_data      (w_tap[g])
            );
        end
    end

    // Replace the oldest sample in the sum, or seed it on prefill
    always_comb begin
        if (r_primed) begin
            n_sum = r_sum - SUM_W'(w_tap[WINDOW_DEPTH-1]) + SUM_W'(i_sample);
        end else begin
            n_sum = SUM_W'(i_sample) * DEPTH_K;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primed <= 1'b0;
            r_valid  <= 1'b0;
            r_sum    <= '0;
        end else begin
            if (w_accept) begin
                r_primed <= 1'b1;
                r_sum    <= n_sum;
                r_valid  <= 1'b1;
            end else if (!i_stall) begin
                r_valid  <= 1'b0;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_sum   = r_sum;

endmodule

@@ rtl/blam_scale.sv @@
// Scaling pipeline: mean, millivolts and charge percentage with per-stage stall.
module blam_scale #(
    parameter int WINDOW_DEPTH = 32,
    parameter int SUM_W        = blam_pkg::SAMPLE_W + $clog2(WINDOW_DEPTH)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  blam_pkg::t_cfg                i_cfg,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [SUM_W-1:0]              i_sum,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [blam_pkg::SAMPLE_W-1:0] o_mean,
    output logic [blam_pkg::MV_W-1:0]     o_mv,
    output logic [blam_pkg::PCT_W-1:0]    o_pct
);

    // floor(sum / depth) as (sum * REC_MUL) >> REC_SHIFT, exact over the sum range
    localparam int          DEPTH_W   = $clog2(WINDOW_DEPTH);
    localparam int          REC_SHIFT = SUM_W + DEPTH_W;
    localparam int          REC_W     = SUM_W + 2;
    localparam int          PROD_W    = SUM_W + REC_W;
    localparam logic [63:0] REC_FULL  =
        ((64'd1 << REC_SHIFT) + 64'(WINDOW_DEPTH) - 64'd1) / 64'(WINDOW_DEPTH);
    localparam logic [REC_W-1:0] REC_MUL = REC_FULL[REC_W-1:0];

    logic                          r_v2, r_v3, r_v4, r_v5;
    logic                          w_adv2, w_adv3, w_adv4, w_adv5;
    logic [PROD_W-1:0]             r_prod;
    logic [blam_pkg::SAMPLE_W-1:0] r_mean3, r_mean4, r_mean5;
    logic [blam_pkg::MVP_W-1:0]    r_mvp;
    logic [blam_pkg::MV_W-1:0]     r_mv4, r_mv5;
    logic [blam_pkg::PCT_W-1:0]    r_pct5;
    logic [blam_pkg::SAMPLE_W-1:0] w_mean;
    logic [blam_pkg::MVP_W:0]      w_qsum;
    logic [blam_pkg::MV_W-1:0]     w_diff;
    logic [blam_pkg::DIV10_PROD_W-1:0] w_div10;
    logic [blam_pkg::PCT_W-1:0]    w_pct;

    // Advance a stage when it is empty or the next one advances
    assign w_adv5  = !r_v5 || !i_stall;
    assign w_adv4  = !r_v4 || w_adv5;
    assign w_adv3  = !r_v3 || w_adv4;
    assign w_adv2  = !r_v2 || w_adv3;
    assign o_stall = !w_adv2;

    assign w_mean = r_prod[REC_SHIFT +: blam_pkg::SAMPLE_W];

    // Divide the millivolt product by 65535
    assign w_qsum = {1'b0, r_mvp}
                  + (blam_pkg::MVP_W + 1)'(r_mvp >> blam_pkg::ADC_DIV_SHIFT)
                  + (blam_pkg::MVP_W + 1)'(1);

    // Percentage above the empty threshold, saturated at the top
    assign w_diff  = r_mv4 - i_cfg.empty_mv;
    assign w_div10 = blam_pkg::DIV10_PROD_W'(w_diff[blam_pkg::PCT_DIFF_W-1:0])
                   * blam_pkg::DIV10_PROD_W'(blam_pkg::DIV10_MUL);

    always_comb begin
        if (r_mv4 < i_cfg.empty_mv) begin
            w_pct = '0;
        end else if (w_diff >= blam_pkg::PCT_SAT_MV) begin
            w_pct = blam_pkg::PCT_MAX;
        end else begin
            w_pct = w_div10[blam_pkg::DIV10_SHIFT +: blam_pkg::PCT_W];
        end
    end

    // Control: stage valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (w_adv2) r_v2 <= i_valid;
            if (w_adv3) r_v3 <= r_v2;
            if (w_adv4) r_v4 <= r_v3;
            if (w_adv5) r_v5 <= r_v4;
        end
    end

    // Payload: reciprocal multiply, full-scale multiply, divide by 65535, percentage
    always_ff @(posedge i_clk) begin
        if (w_adv2) begin
            r_prod <= PROD_W'(i_sum) * PROD_W'(REC_MUL);
        end
        if (w_adv3) begin
            r_mean3 <= w_mean;
            r_mvp   <= blam_pkg::MVP_W'(w_mean) * blam_pkg::MVP_W'(i_cfg.full_scale_mv);
        end
        if (w_adv4) begin
            r_mean4 <= r_mean3;
            r_mv4   <= w_qsum[blam_pkg::ADC_DIV_SHIFT +: blam_pkg::MV_W];
        end
        if (w_adv5) begin
            r_mean5 <= r_mean4;
            r_mv5   <= r_mv4;
            r_pct5  <= w_pct;
        end
    end

    assign o_valid = r_v5;
    assign o_mean  = r_mean5;
    assign o_mv    = r_mv5;
    assign o_pct   = r_pct5;

endmodule

@@ rtl/blam_checker.sv @@
// Port-level checks for the battery level averager, bound to the top level.
module blam_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input logic [blam_pkg::SAMPLE_W-1:0]   o_window_mean,
    input logic [blam_pkg::MV_W-1:0]       o_battery_millivolts,
    input logic [blam_pkg::PCT_W-1:0]      o_charge_percent
);

    // Reset empties the pipeline
    a_reset_drains: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered right after reset");

    // Hold a stalled result transaction
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_window_mean)
            && $stable(o_battery_millivolts) && $stable(o_charge_percent)))
        else $error("stalled result changed");

    // Percentage never exceeds the clamp
    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_charge_percent <= blam_pkg::PCT_MAX))
        else $error("charge percentage above clamp");

    // A nonzero percentage needs at least ten millivolts
    a_pct_needs_mv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_charge_percent != '0))
            |-> (o_battery_millivolts >= blam_pkg::MV_W'(10)))
        else $error("percentage without millivolts");

endmodule

bind battery_level_averager blam_checker u_blam_checker (.*);
